// ===== src/tqe_pkg.sv =====
// Shared types and codes for the timer queue expiry engine.
// Used by tqe_ctrl, tqe_datapath and timer_queue_expiry_engine.
package tqe_pkg;

   localparam logic [1:0] FUNC_ADD    = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_TICK   = 2'd2;
   localparam logic [1:0] FUNC_NOP    = 2'd3;

   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_FIRED = 2'd1;
   localparam logic [1:0] STAT_IDLE  = 2'd2;
   localparam logic [1:0] STAT_FULL  = 2'd3;

   // Controller states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_APPLY  = 5'b00100,
      ST_RESULT = 5'b01000,
      ST_SPARE  = 5'b10000
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;     // capture request, restart scan
      logic step;     // examine one slot
      logic apply;    // commit the state update and the result
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic scan_last; // slot being examined is the last one
   } sts_type;

endpackage

// ===== src/tqe_ctrl.sv =====
// Sequencer of the timer queue: load, scan all slots, apply, present result.
// Depends on tqe_pkg.
module tqe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tqe_pkg::cmd_type  cmd,
   input  tqe_pkg::sts_type  sts
);

   tqe_pkg::state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tqe_pkg::ST_IDLE:   if (req_valid) state_in = tqe_pkg::ST_SCAN;
         tqe_pkg::ST_SCAN:   if (sts.scan_last) state_in = tqe_pkg::ST_APPLY;
         tqe_pkg::ST_APPLY:  state_in = tqe_pkg::ST_RESULT;
         tqe_pkg::ST_RESULT: if (rsp_ready) state_in = tqe_pkg::ST_IDLE;
         default:            state_in = tqe_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= tqe_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_ready = (state_ff == tqe_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == tqe_pkg::ST_RESULT);
   assign cmd.load  = req_ready && req_valid;
   assign cmd.step  = (state_ff == tqe_pkg::ST_SCAN);
   assign cmd.apply = (state_ff == tqe_pkg::ST_APPLY);

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.step) else $error("scan did not follow load");
   a_result: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> rsp_valid) else $error("result did not follow apply");

endmodule

// ===== src/tqe_datapath.sv =====
// Slot table, sequential earliest-expiry / free-slot / id-match scan, update.
// Depends on tqe_pkg.
module tqe_datapath #(
   parameter int NUM_TIMERS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  tqe_pkg::cmd_type  cmd,
   output tqe_pkg::sts_type  sts,
   input  logic [1:0]        req_func,
   input  logic [15:0]       req_event_handle,
   input  logic [47:0]       req_time_value,
   input  logic [31:0]       req_repeat_interval,
   input  logic [31:0]       req_target_id,
   output logic [1:0]        rsp_status,
   output logic [31:0]       rsp_result_id,
   output logic [15:0]       rsp_fired_handle
);

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   // Slot table
   logic [NUM_TIMERS-1:0] valid_ff;
   logic [31:0] id_ff     [NUM_TIMERS];
   logic [15:0] handle_ff [NUM_TIMERS];
   logic [47:0] expiry_ff [NUM_TIMERS];
   logic [31:0] period_ff [NUM_TIMERS];
   logic [31:0] order_ff  [NUM_TIMERS];
   logic [31:0] last_id_ff, ins_cnt_ff;

   // Captured request
   logic [1:0]  func_ff;
   logic [15:0] hdl_ff;
   logic [47:0] tval_ff;
   logic [31:0] per_ff, tgt_ff;

   // Scan state
   logic [IW-1:0] idx_ff;
   logic          free_found_ff, best_found_ff;
   logic [IW-1:0] free_idx_ff, best_idx_ff;
   logic [47:0]   best_exp_ff;
   logic [31:0]   best_ord_ff;
   logic [NUM_TIMERS-1:0] kill_ff;

   logic [1:0]  status_ff;
   logic [31:0] rid_ff;
   logic [15:0] rhdl_ff;

   logic better;
   assign sts.scan_last = (idx_ff == IW'(NUM_TIMERS-1));
   assign better = valid_ff[idx_ff] && (!best_found_ff ||
      expiry_ff[idx_ff] < best_exp_ff ||
      (expiry_ff[idx_ff] == best_exp_ff && order_ff[idx_ff] < best_ord_ff));

   // Request capture and slot scan
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;  hdl_ff <= req_event_handle;
         tval_ff <= req_time_value;
         per_ff <= req_repeat_interval;  tgt_ff <= req_target_id;
         idx_ff <= '0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
         kill_ff <= '0;
      end else if (cmd.step) begin
         idx_ff <= idx_ff + 1'b1;
         if (!valid_ff[idx_ff] && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= idx_ff;
         end
         if (better) begin
            best_found_ff <= 1'b1;
            best_idx_ff   <= idx_ff;
            best_exp_ff   <= expiry_ff[idx_ff];
            best_ord_ff   <= order_ff[idx_ff];
         end
         kill_ff[idx_ff] <= valid_ff[idx_ff] && (id_ff[idx_ff] == tgt_ff);
      end
   end

   // Table update and result
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         last_id_ff <= '0;
         ins_cnt_ff <= '0;
      end else if (cmd.apply) begin
         unique case (func_ff)
            tqe_pkg::FUNC_ADD: begin
               rhdl_ff <= '0;
               if (!free_found_ff) begin
                  status_ff <= tqe_pkg::STAT_FULL;
                  rid_ff    <= '0;
               end else begin
                  status_ff <= tqe_pkg::STAT_DONE;
                  last_id_ff <= last_id_ff + 32'd1;
                  rid_ff <= last_id_ff + 32'd1;
                  valid_ff[free_idx_ff]  <= 1'b1;
                  id_ff[free_idx_ff]     <= last_id_ff + 32'd1;
                  handle_ff[free_idx_ff] <= hdl_ff;
                  expiry_ff[free_idx_ff] <= tval_ff;
                  period_ff[free_idx_ff] <= per_ff;
                  order_ff[free_idx_ff]  <= ins_cnt_ff;
                  ins_cnt_ff <= ins_cnt_ff + 32'd1;
               end
            end
            tqe_pkg::FUNC_REMOVE: begin
               status_ff <= tqe_pkg::STAT_DONE;
               rid_ff    <= '0;
               rhdl_ff   <= '0;
               valid_ff  <= valid_ff & ~kill_ff;
            end
            tqe_pkg::FUNC_TICK: begin
               if (!best_found_ff || best_exp_ff > tval_ff) begin
                  status_ff <= tqe_pkg::STAT_IDLE;
                  rid_ff    <= '0;
                  rhdl_ff   <= '0;
               end else begin
                  status_ff <= tqe_pkg::STAT_FIRED;
                  rid_ff  <= id_ff[best_idx_ff];
                  rhdl_ff <= handle_ff[best_idx_ff];
                  if (period_ff[best_idx_ff] == 32'd0) begin
                     valid_ff[best_idx_ff] <= 1'b0;
                  end else begin
                     expiry_ff[best_idx_ff] <= tval_ff + 48'(period_ff[best_idx_ff]);
                     order_ff[best_idx_ff]  <= ins_cnt_ff;
                     ins_cnt_ff <= ins_cnt_ff + 32'd1;
                  end
               end
            end
            default: begin
               status_ff <= tqe_pkg::STAT_DONE;
               rid_ff    <= '0;
               rhdl_ff   <= '0;
            end
         endcase
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_result_id    = rid_ff;
   assign rsp_fired_handle = rhdl_ff;

   a_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && func_ff == tqe_pkg::FUNC_ADD && !free_found_ff) |-> (&valid_ff))
      else $error("full reported with free slot");
   a_best_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && func_ff == tqe_pkg::FUNC_TICK && best_found_ff) |-> valid_ff[best_idx_ff])
      else $error("best slot not valid");
   a_add_id: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && func_ff == tqe_pkg::FUNC_ADD && free_found_ff)
      |=> last_id_ff == $past(last_id_ff) + 32'd1) else $error("id not advanced");

endmodule

// ===== src/timer_queue_expiry_engine.sv =====
// Timer queue expiry engine, top level.
// Each accepted request runs a serial scan of the slot table (one slot per
// scan cycle), then an apply step, before the result is valid. No new
// request is accepted until that result is taken. Synchronous active-high
// reset empties the table and clears the id and insertion counters.
module timer_queue_expiry_engine #(
   parameter int NUM_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_event_handle,
   input  logic [47:0] req_time_value,
   input  logic [31:0] req_repeat_interval,
   input  logic [31:0] req_target_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_result_id,
   output logic [15:0] rsp_fired_handle
);

   tqe_pkg::cmd_type cmd;
   tqe_pkg::sts_type sts;

   tqe_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .sts
   );

   tqe_datapath #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_func, .req_event_handle, .req_time_value, .req_repeat_interval,
      .req_target_id, .rsp_status, .rsp_result_id, .rsp_fired_handle
   );

endmodule
